/* hdl/cbm_pkg.sv */
// ----------------------------------------------------------------------------
// cbm_pkg
// Types and constants shared by the cartridge bank mapper and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package cbm_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 4;

   localparam logic [CsrIndexWidth-1:0] CSR_FLASH_CART_MODE = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_CART_HAS_RAM    = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_CART_HAS_RUMBLE = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_ROM_SIZE_CODE   = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_RAM_SIZE_CODE   = 3'd4;

   localparam logic ACTION_READ  = 1'b0;
   localparam logic ACTION_WRITE = 1'b1;

   localparam logic [7:0] FLASH_EXEC_KEY   = 8'hA5;
   localparam logic [7:0] FLASH_DONE_FLAGS = 8'hF0;

   typedef enum logic [1:0] {
      TARGET_NONE     = 2'd0,
      TARGET_ROM      = 2'd1,
      TARGET_RAM      = 2'd2,
      TARGET_RAM_OFF  = 2'd3
   } target_type;

   typedef struct packed {
      logic        action;
      logic [15:0] bus_address;
      logic [7:0]  bus_data;
   } req_type;

   typedef struct packed {
      target_type  target;
      logic [22:0] rom_address;
      logic [16:0] ram_address;
      logic        ram_write;
      logic [7:0]  write_data;
      logic        rumble_on;
      logic        reset_request;
      logic [5:0]  flash_index;
      logic [7:0]  flash_status;
      logic        ram_enabled;
   } rsp_type;

   typedef struct packed {
      logic       flash_cart_mode;
      logic       cart_has_ram;
      logic       cart_has_rumble;
      logic [3:0] rom_size_code;
      logic [2:0] ram_size_code;
   } cfg_type;

endpackage

`default_nettype wire

/* hdl/cbm_mapper.sv */
// ----------------------------------------------------------------------------
// cbm_mapper
// Mapper registers and the address decode of one bus transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_mapper (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            step,
   input  wire cbm_pkg::req_type req,
   input  wire cbm_pkg::cfg_type cfg,
   output cbm_pkg::rsp_type     rsp
);

   logic       ram_enable_ff,   ram_enable_in;
   logic [8:0] rom_bank_ff,     rom_bank_in;
   logic [3:0] ram_bank_ff,     ram_bank_in;
   logic       rumble_ff,       rumble_in;
   logic [7:0] flash_cmd_ff,    flash_cmd_in;
   logic [7:0] flash_status_ff, flash_status_in;
   logic [5:0] flash_index_ff,  flash_index_in;

   logic [15:0] addr;
   logic [7:0]  data;
   logic        is_write;
   logic        in_ram;
   logic        in_port;
   logic        reset_req;

   assign addr     = req.bus_address;
   assign data     = req.bus_data;
   assign is_write = (req.action == cbm_pkg::ACTION_WRITE);
   assign in_ram   = (addr[15:13] == 3'b101);
   assign in_port  = (addr[15:5] == 11'h009);

   always_comb begin
      ram_enable_in   = ram_enable_ff;
      rom_bank_in     = rom_bank_ff;
      ram_bank_in     = ram_bank_ff;
      rumble_in       = rumble_ff;
      flash_cmd_in    = flash_cmd_ff;
      flash_status_in = flash_status_ff;
      flash_index_in  = flash_index_ff;
      reset_req       = 1'b0;
      if (is_write && !addr[15]) begin
         case (addr[14:12])
            3'd0, 3'd1: begin
               if (!cfg.flash_cart_mode) begin
                  if (data[3:0] == 4'hA) begin
                     if (cfg.cart_has_ram) begin
                        ram_enable_in = 1'b1;
                     end
                  end else begin
                     ram_enable_in = 1'b0;
                  end
               end else if (in_port) begin
                  if (addr[4:0] == 5'h00) begin
                     flash_cmd_in    = data;
                     flash_status_in = 8'h00;
                  end else if (addr[4:0] == 5'h01) begin
                     flash_status_in = flash_status_ff | 8'h01;
                  end else if (addr[4:0] == 5'h02) begin
                     flash_status_in = flash_status_ff | 8'h02;
                  end else if (addr[4:0] == 5'h1F && data == cbm_pkg::FLASH_EXEC_KEY) begin
                     if (flash_cmd_ff[7:6] == 2'b10) begin
                        flash_index_in  = flash_cmd_ff[5:0];
                        flash_status_in = cbm_pkg::FLASH_DONE_FLAGS;
                        reset_req       = 1'b1;
                     end else if (flash_cmd_ff[7:6] == 2'b11) begin
                        flash_index_in  = flash_cmd_ff[5:0];
                        flash_status_in = flash_status_ff | cbm_pkg::FLASH_DONE_FLAGS;
                        reset_req       = 1'b1;
                     end
                  end
               end
            end
            3'd2: begin
               rom_bank_in = {rom_bank_ff[8], data};
            end
            3'd3: begin
               if (cfg.rom_size_code > 4'd7) begin
                  rom_bank_in = {data[0], rom_bank_ff[7:0]};
               end
            end
            3'd4, 3'd5: begin
               if (cfg.cart_has_rumble) begin
                  ram_bank_in = {1'b0, data[2:0]};
                  rumble_in   = data[3];
               end else begin
                  ram_bank_in = data[3:0];
               end
               if (cfg.ram_size_code < 3'd3) begin
                  ram_bank_in = 4'd0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp             = '0;
      rsp.target      = cbm_pkg::TARGET_NONE;
      if (in_ram) begin
         if (ram_enable_ff) begin
            rsp.target      = cbm_pkg::TARGET_RAM;
            rsp.ram_address = {ram_bank_ff, addr[12:0]};
            if (is_write) begin
               rsp.ram_write  = 1'b1;
               rsp.write_data = data;
            end
         end else begin
            rsp.target = cbm_pkg::TARGET_RAM_OFF;
         end
      end else if (!is_write && !addr[15]) begin
         rsp.target = cbm_pkg::TARGET_ROM;
         if (addr[14]) begin
            rsp.rom_address = {rom_bank_ff, addr[13:0]};
         end else begin
            rsp.rom_address = {9'd0, addr[13:0]};
         end
      end
      rsp.rumble_on     = rumble_in;
      rsp.reset_request = reset_req;
      rsp.flash_index   = flash_index_in;
      rsp.flash_status  = flash_status_in;
      rsp.ram_enabled   = ram_enable_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_enable_ff   <= 1'b0;
         rom_bank_ff     <= 9'd1;
         ram_bank_ff     <= 4'd0;
         rumble_ff       <= 1'b0;
         flash_cmd_ff    <= 8'h00;
         flash_status_ff <= 8'h00;
         flash_index_ff  <= 6'd0;
      end else if (step) begin
         ram_enable_ff   <= ram_enable_in;
         rom_bank_ff     <= rom_bank_in;
         ram_bank_ff     <= ram_bank_in;
         rumble_ff       <= rumble_in;
         flash_cmd_ff    <= flash_cmd_in;
         flash_status_ff <= flash_status_in;
         flash_index_ff  <= flash_index_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/cartridge_bank_mapper_unit.sv */
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_unit
// Banked cartridge mapper with a multi-game flash command port.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid/req_ready    cbm_pkg::req_type
//   rsp      out        rsp_valid/rsp_ready    cbm_pkg::rsp_type
//   csr      in         csr_we                 csr_index, csr_wdata
//
// Each transaction is decoded combinationally; its result appears in the output register
// on the following cycle. A new transaction is accepted every cycle while the
// output register is empty or being drained, so the output register alone sets
// the rate. Reset is synchronous and returns all mapper and control registers
// to their power-on values. A stalled result holds until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module cartridge_bank_mapper_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire cbm_pkg::req_type                    req_data,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output cbm_pkg::rsp_type                         rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [cbm_pkg::CsrIndexWidth-1:0]   csr_index,
   input  wire logic [cbm_pkg::CsrDataWidth-1:0]    csr_wdata
);

   cbm_pkg::cfg_type cfg_ff, cfg_in;
   cbm_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   cbm_mapper u_mapper (
      .clock (clock),
      .reset (reset),
      .step  (accept),
      .req   (req_data),
      .cfg   (cfg_ff),
      .rsp   (rsp_in)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            cbm_pkg::CSR_FLASH_CART_MODE: cfg_in.flash_cart_mode = csr_wdata[0];
            cbm_pkg::CSR_CART_HAS_RAM:    cfg_in.cart_has_ram    = csr_wdata[0];
            cbm_pkg::CSR_CART_HAS_RUMBLE: cfg_in.cart_has_rumble = csr_wdata[0];
            cbm_pkg::CSR_ROM_SIZE_CODE:   cfg_in.rom_size_code   = csr_wdata[3:0];
            cbm_pkg::CSR_RAM_SIZE_CODE:   cfg_in.ram_size_code   = csr_wdata[2:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flash_cart_mode <= 1'b0;
         cfg_ff.cart_has_ram    <= 1'b1;
         cfg_ff.cart_has_rumble <= 1'b0;
         cfg_ff.rom_size_code   <= 4'd0;
         cfg_ff.ram_size_code   <= 3'd0;
         rsp_valid_ff           <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/cbm_checker.sv */
// ----------------------------------------------------------------------------
// cbm_checker
// Port-level checks of the cartridge bank mapper, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire cbm_pkg::rsp_type rsp_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled result changed or was dropped.");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("Accepted transaction produced no result.");

   a_ram_write_target: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.ram_write |-> rsp_data.target == cbm_pkg::TARGET_RAM)
      else $error("RAM write strobe outside an enabled RAM access.");

   a_reset_req_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.reset_request |->
         rsp_data.flash_status[7:4] == 4'hF && rsp_data.target == cbm_pkg::TARGET_NONE)
      else $error("Flash map command result is inconsistent.");

endmodule

bind cartridge_bank_mapper_unit cbm_checker u_cbm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready)
);

`default_nettype wire
